// ----- rtl/assert_macros.svh -----
// assertion macros shared by the quad4 gauss point geometry rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define QG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define QG_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- rtl/qg_pkg.sv -----
// types, widths and constant tables of the quad4 gauss point geometry core
// no dependencies
package qg_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WFRAC     = 16;
   localparam int W_W       = 19;
   localparam int CRD_W     = 32;
   localparam int VOL_W     = 48;
   localparam int LANES     = 8;
   localparam int Q_W       = 32;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = 2;

   localparam logic [W_W-1:0] WEIGHT_RESET = W_W'(65536);

   localparam longint ONE = longint'(1) << FRAC_BITS;
   localparam longint GP  = (64'sd57735027 * ONE + 64'sd50000000) / 64'sd100000000;

   localparam int NAT_W  = FRAC_BITS + 1;
   localparam int SHP_W  = FRAC_BITS + 1;
   localparam int PN_W   = CRD_W + SHP_W + 1;
   localparam int JP_W   = CRD_W + NAT_W + 2;
   localparam int NP_W   = CRD_W + NAT_W + 1;
   localparam int D_W    = 2 * CRD_W;
   localparam int DETF_W = 2 * CRD_W + 1 - FRAC_BITS;
   localparam int NUM_W  = NP_W + 1;
   localparam int DEN_W  = DETF_W + 1;
   localparam int VH_W   = DETF_W - WFRAC + W_W + 1;
   localparam int VL_W   = WFRAC + W_W;
   localparam int VO_W   = VH_W + 1;

   typedef struct packed {
      logic [NAT_W-1:0] a;
      logic [NAT_W-1:0] b;
      logic [NAT_W-1:0] c;
      logic [NAT_W-1:0] d;
   } nat_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] point_x;
      logic signed [CRD_W-1:0] point_y;
      logic signed [VOL_W-1:0] volume;
      logic                    degenerate;
   } side_type;

   typedef struct packed {
      side_type                      side;
      logic [DEN_W-1:0]              den;
      logic [LANES-1:0]              neg;
      logic [LANES-1:0][NUM_W-1:0]   num;
   } work_type;

   typedef struct packed {
      logic signed [CRD_W-1:0]     point_x;
      logic signed [CRD_W-1:0]     point_y;
      logic signed [VOL_W-1:0]     point_volume;
      logic [3:0][CRD_W-1:0]       dx;
      logic [3:0][CRD_W-1:0]       dy;
      logic                        degenerate;
   } rsp_type;

   function automatic nat_type nat_coords(input logic [1:0] idx);
      nat_type r;
      longint  xi;
      longint  eta;
      xi  = idx[1] ? GP : -GP;
      eta = idx[0] ? GP : -GP;
      r.a = NAT_W'(ONE - xi);
      r.b = NAT_W'(ONE + xi);
      r.c = NAT_W'(ONE - eta);
      r.d = NAT_W'(ONE + eta);
      return r;
   endfunction

   // bilinear shape function value at the gauss point, rounded to the fixed point grid
   function automatic logic [SHP_W-1:0] shape_val(input logic [1:0] idx,
                                                  input logic [1:0] node);
      nat_type t;
      longint  s;
      longint  u;
      longint  p;
      t = nat_coords(idx);
      s = (node == 2'd0 || node == 2'd3) ? longint'(t.a) : longint'(t.b);
      u = (node == 2'd0 || node == 2'd1) ? longint'(t.c) : longint'(t.d);
      p = s * u;
      return SHP_W'((p + (longint'(1) << (FRAC_BITS + 1))) >> (FRAC_BITS + 2));
   endfunction

endpackage

// ----- rtl/qg_front.sv -----
// front pipeline: shape functions, position, jacobian, determinant, volume, numerators
// depends on qg_pkg
module qg_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [qg_pkg::W_W-1:0]              weight,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  logic signed [qg_pkg::CRD_W-1:0]     in_x [4],
   input  logic signed [qg_pkg::CRD_W-1:0]     in_y [4],
   input  logic [1:0]                          in_idx,
   input  logic                                out_full,
   output logic                                out_valid,
   output qg_pkg::work_type                    out_item
);

   localparam int F     = qg_pkg::FRAC_BITS;
   localparam int CRD_W = qg_pkg::CRD_W;
   localparam int NAT_W = qg_pkg::NAT_W;
   localparam int SHP_W = qg_pkg::SHP_W;
   localparam int PN_W  = qg_pkg::PN_W;
   localparam int JP_W  = qg_pkg::JP_W;
   localparam int NP_W  = qg_pkg::NP_W;
   localparam int D_W   = qg_pkg::D_W;
   localparam int DT_W  = D_W + 1;
   localparam int DETF_W = qg_pkg::DETF_W;
   localparam int NUM_W = qg_pkg::NUM_W;
   localparam int DEN_W = qg_pkg::DEN_W;
   localparam int VH_W  = qg_pkg::VH_W;
   localparam int VL_W  = qg_pkg::VL_W;
   localparam int VO_W  = qg_pkg::VO_W;
   localparam int VOL_W = qg_pkg::VOL_W;
   localparam int WFRAC = qg_pkg::WFRAC;
   localparam int W_W   = qg_pkg::W_W;
   localparam int LANES = qg_pkg::LANES;
   localparam int PS_W  = PN_W + 3;
   localparam int JS_W  = JP_W + 2;
   localparam int HI_W  = DETF_W - WFRAC;

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;

   // stage 1
   logic signed [CRD_W-1:0] s1_x_ff [4];
   logic signed [CRD_W-1:0] s1_y_ff [4];
   logic [1:0]              s1_idx_ff;

   // stage 2
   qg_pkg::nat_type         nat2;
   logic signed [SHP_W:0]   shp [4];
   logic signed [NAT_W:0]   as2, bs2, cs2, ds2;
   logic signed [CRD_W:0]   dif [8];
   logic signed [PN_W-1:0]  s2_pnx_in [4];
   logic signed [PN_W-1:0]  s2_pny_in [4];
   logic signed [JP_W-1:0]  s2_jp_in [8];
   logic signed [PN_W-1:0]  s2_pnx_ff [4];
   logic signed [PN_W-1:0]  s2_pny_ff [4];
   logic signed [JP_W-1:0]  s2_jp_ff [8];
   logic [1:0]              s2_idx_ff;

   // stage 3
   logic signed [PS_W-1:0]  psx, psy;
   logic signed [JS_W-1:0]  js [4];
   logic signed [CRD_W-1:0] s3_px_in, s3_py_in;
   logic signed [CRD_W-1:0] s3_j_in [4];
   logic signed [CRD_W-1:0] s3_px_ff, s3_py_ff;
   logic signed [CRD_W-1:0] s3_j_ff [4];
   logic [1:0]              s3_idx_ff;

   // stage 4
   qg_pkg::nat_type         nat4;
   logic signed [NAT_W:0]   as4, bs4, cs4, ds4;
   logic signed [D_W-1:0]   s4_d0_ff, s4_d1_ff;
   logic signed [NP_W-1:0]  s4_np_in [8];
   logic signed [NP_W-1:0]  s4_np_ff [8];
   logic signed [CRD_W-1:0] s4_px_ff, s4_py_ff;

   // stage 5
   logic signed [DT_W-1:0]   det;
   logic signed [DT_W-1:0]   detr;
   logic signed [DETF_W-1:0] s5_detf_in;
   logic signed [NUM_W-1:0]  s5_num_in [LANES];
   logic signed [DETF_W-1:0] s5_detf_ff;
   logic signed [NUM_W-1:0]  s5_num_ff [LANES];
   logic signed [CRD_W-1:0]  s5_px_ff, s5_py_ff;

   // stage 6
   logic signed [HI_W-1:0]   vhi_op;
   logic signed [W_W:0]      ws;
   logic [LANES-1:0]         s6_neg_in;
   logic [LANES-1:0][NUM_W-1:0] s6_num_in;
   logic signed [VH_W-1:0]   s6_vhi_ff;
   logic [VL_W-1:0]          s6_vlo_ff;
   logic                     s6_degen_ff;
   logic [DEN_W-1:0]         s6_den_ff;
   logic [LANES-1:0]         s6_neg_ff;
   logic [LANES-1:0][NUM_W-1:0] s6_num_ff;
   logic signed [CRD_W-1:0]  s6_px_ff, s6_py_ff;

   // stage 7
   logic [VL_W:0]            vlo_r;
   logic signed [VO_W-1:0]   vol;
   qg_pkg::work_type         item_in;
   qg_pkg::work_type         item_ff;

   assign adv      = !(v7_ff && out_full);
   assign in_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // stage 2: products with shape values and natural coordinates
   always_comb begin
      nat2 = qg_pkg::nat_coords(s1_idx_ff);
      as2 = $signed({1'b0, nat2.a});
      bs2 = $signed({1'b0, nat2.b});
      cs2 = $signed({1'b0, nat2.c});
      ds2 = $signed({1'b0, nat2.d});
      for (int i = 0; i < 4; i++) begin
         shp[i] = $signed({1'b0, qg_pkg::shape_val(s1_idx_ff, 2'(i))});
         s2_pnx_in[i] = shp[i] * s1_x_ff[i];
         s2_pny_in[i] = shp[i] * s1_y_ff[i];
      end
      dif[0] = (CRD_W+1)'(s1_x_ff[1]) - (CRD_W+1)'(s1_x_ff[0]);
      dif[1] = (CRD_W+1)'(s1_x_ff[2]) - (CRD_W+1)'(s1_x_ff[3]);
      dif[2] = (CRD_W+1)'(s1_y_ff[1]) - (CRD_W+1)'(s1_y_ff[0]);
      dif[3] = (CRD_W+1)'(s1_y_ff[2]) - (CRD_W+1)'(s1_y_ff[3]);
      dif[4] = (CRD_W+1)'(s1_x_ff[3]) - (CRD_W+1)'(s1_x_ff[0]);
      dif[5] = (CRD_W+1)'(s1_x_ff[2]) - (CRD_W+1)'(s1_x_ff[1]);
      dif[6] = (CRD_W+1)'(s1_y_ff[3]) - (CRD_W+1)'(s1_y_ff[0]);
      dif[7] = (CRD_W+1)'(s1_y_ff[2]) - (CRD_W+1)'(s1_y_ff[1]);
      s2_jp_in[0] = cs2 * dif[0];
      s2_jp_in[1] = ds2 * dif[1];
      s2_jp_in[2] = cs2 * dif[2];
      s2_jp_in[3] = ds2 * dif[3];
      s2_jp_in[4] = as2 * dif[4];
      s2_jp_in[5] = bs2 * dif[5];
      s2_jp_in[6] = as2 * dif[6];
      s2_jp_in[7] = bs2 * dif[7];
   end

   // stage 3: sums, rounding and saturation
   always_comb begin
      psx = PS_W'(s2_pnx_ff[0]) + PS_W'(s2_pnx_ff[1]) + PS_W'(s2_pnx_ff[2])
          + PS_W'(s2_pnx_ff[3]) + (PS_W'(1) <<< (F - 1));
      psy = PS_W'(s2_pny_ff[0]) + PS_W'(s2_pny_ff[1]) + PS_W'(s2_pny_ff[2])
          + PS_W'(s2_pny_ff[3]) + (PS_W'(1) <<< (F - 1));
      psx = psx >>> F;
      psy = psy >>> F;
      if (psx[PS_W-1:CRD_W-1] == '0 || psx[PS_W-1:CRD_W-1] == '1) begin
         s3_px_in = psx[CRD_W-1:0];
      end else begin
         s3_px_in = psx[PS_W-1] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
      end
      if (psy[PS_W-1:CRD_W-1] == '0 || psy[PS_W-1:CRD_W-1] == '1) begin
         s3_py_in = psy[CRD_W-1:0];
      end else begin
         s3_py_in = psy[PS_W-1] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
      end
      for (int j = 0; j < 4; j++) begin
         js[j] = JS_W'(s2_jp_ff[2*j]) + JS_W'(s2_jp_ff[2*j+1]) + (JS_W'(1) <<< (F + 1));
         js[j] = js[j] >>> (F + 2);
         if ((js[j][JS_W-1:CRD_W-1] == '0 || js[j][JS_W-1:CRD_W-1] == '1)
             && js[j][CRD_W-1:0] != {1'b1, {(CRD_W-1){1'b0}}}) begin
            s3_j_in[j] = js[j][CRD_W-1:0];
         end else begin
            s3_j_in[j] = js[j][JS_W-1] ? {1'b1, {(CRD_W-2){1'b0}}, 1'b1}
                                       : {1'b0, {(CRD_W-1){1'b1}}};
         end
      end
   end

   // stage 4: determinant products and numerator products
   always_comb begin
      nat4 = qg_pkg::nat_coords(s3_idx_ff);
      as4 = $signed({1'b0, nat4.a});
      bs4 = $signed({1'b0, nat4.b});
      cs4 = $signed({1'b0, nat4.c});
      ds4 = $signed({1'b0, nat4.d});
      s4_np_in[0] = s3_j_ff[3] * cs4;
      s4_np_in[1] = s3_j_ff[3] * ds4;
      s4_np_in[2] = s3_j_ff[1] * as4;
      s4_np_in[3] = s3_j_ff[1] * bs4;
      s4_np_in[4] = s3_j_ff[0] * as4;
      s4_np_in[5] = s3_j_ff[0] * bs4;
      s4_np_in[6] = s3_j_ff[2] * cs4;
      s4_np_in[7] = s3_j_ff[2] * ds4;
   end

   // stage 5: determinant rounding and derivative numerators
   always_comb begin
      det  = DT_W'(s4_d0_ff) - DT_W'(s4_d1_ff);
      detr = (det + (DT_W'(1) <<< (F - 1))) >>> F;
      s5_detf_in = detr[DETF_W-1:0];
      s5_num_in[0] = NUM_W'(s4_np_ff[2]) - NUM_W'(s4_np_ff[0]);
      s5_num_in[1] = NUM_W'(s4_np_ff[0]) + NUM_W'(s4_np_ff[3]);
      s5_num_in[2] = NUM_W'(s4_np_ff[1]) - NUM_W'(s4_np_ff[3]);
      s5_num_in[3] = -NUM_W'(s4_np_ff[1]) - NUM_W'(s4_np_ff[2]);
      s5_num_in[4] = NUM_W'(s4_np_ff[6]) - NUM_W'(s4_np_ff[4]);
      s5_num_in[5] = -NUM_W'(s4_np_ff[5]) - NUM_W'(s4_np_ff[6]);
      s5_num_in[6] = NUM_W'(s4_np_ff[5]) - NUM_W'(s4_np_ff[7]);
      s5_num_in[7] = NUM_W'(s4_np_ff[4]) + NUM_W'(s4_np_ff[7]);
   end

   // stage 6: weight products, divider operands
   always_comb begin
      vhi_op = HI_W'(s5_detf_ff >>> WFRAC);
      ws     = $signed({1'b0, weight});
      for (int l = 0; l < LANES; l++) begin
         s6_neg_in[l] = s5_num_ff[l][NUM_W-1];
         s6_num_in[l] = (s6_neg_in[l] ? NUM_W'(-s5_num_ff[l]) : NUM_W'(s5_num_ff[l]))
                      + (NUM_W'(s5_detf_ff) << 1);
      end
   end

   // stage 7: volume rounding and saturation
   always_comb begin
      vlo_r = (VL_W+1)'(s6_vlo_ff) + (VL_W+1)'(1 << (WFRAC - 1));
      vol   = VO_W'(s6_vhi_ff) + VO_W'($signed({1'b0, vlo_r[VL_W:WFRAC]}));
      item_in.side.point_x    = s6_px_ff;
      item_in.side.point_y    = s6_py_ff;
      item_in.side.degenerate = s6_degen_ff;
      if (vol[VO_W-1:VOL_W-1] == '0 || vol[VO_W-1:VOL_W-1] == '1) begin
         item_in.side.volume = vol[VOL_W-1:0];
      end else begin
         item_in.side.volume = vol[VO_W-1] ? {1'b1, {(VOL_W-1){1'b0}}}
                                           : {1'b0, {(VOL_W-1){1'b1}}};
      end
      item_in.den = s6_den_ff;
      item_in.neg = s6_neg_ff;
      item_in.num = s6_num_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff   <= in_x;
         s1_y_ff   <= in_y;
         s1_idx_ff <= in_idx;

         s2_pnx_ff <= s2_pnx_in;
         s2_pny_ff <= s2_pny_in;
         s2_jp_ff  <= s2_jp_in;
         s2_idx_ff <= s1_idx_ff;

         s3_px_ff  <= s3_px_in;
         s3_py_ff  <= s3_py_in;
         s3_j_ff   <= s3_j_in;
         s3_idx_ff <= s2_idx_ff;

         s4_d0_ff  <= s3_j_ff[0] * s3_j_ff[3];
         s4_d1_ff  <= s3_j_ff[1] * s3_j_ff[2];
         s4_np_ff  <= s4_np_in;
         s4_px_ff  <= s3_px_ff;
         s4_py_ff  <= s3_py_ff;

         s5_detf_ff <= s5_detf_in;
         s5_num_ff  <= s5_num_in;
         s5_px_ff   <= s4_px_ff;
         s5_py_ff   <= s4_py_ff;

         s6_vhi_ff   <= vhi_op * ws;
         s6_vlo_ff   <= s5_detf_ff[WFRAC-1:0] * weight;
         s6_degen_ff <= (s5_detf_ff[DETF_W-1] || s5_detf_ff == '0);
         s6_den_ff   <= DEN_W'(s5_detf_ff) << 2;
         s6_neg_ff   <= s6_neg_in;
         s6_num_ff   <= s6_num_in;
         s6_px_ff    <= s5_px_ff;
         s6_py_ff    <= s5_py_ff;

         item_ff <= item_in;
      end
   end

   assign out_valid = v7_ff;
   assign out_item  = item_ff;

endmodule

// ----- rtl/qg_queue.sv -----
// short item queue between the front pipeline and the divider back end
// depends on qg_pkg and assert_macros.svh
`include "assert_macros.svh"

module qg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  qg_pkg::work_type  push_item,
   input  logic              pop,
   output logic              full,
   output logic              nonempty,
   output qg_pkg::work_type  head
);

   localparam int DEPTH = qg_pkg::QDEPTH;
   localparam int PW    = qg_pkg::QPTR_W;

   qg_pkg::work_type slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]      count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = slot_ff[rd_ptr_ff];

   `QG_NEVER(a_push_full, clock, reset, push && full, "item pushed into full queue")
   `QG_NEVER(a_pop_empty, clock, reset, pop && !nonempty, "item popped from empty queue")
   `QG_ASSERT(a_count_up, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1), "queue count lost a push")

endmodule

// ----- rtl/qg_divider.sv -----
// pipelined restoring divider, one quotient bit per stage, eight lanes on a shared divisor
// depends on qg_pkg
module qg_divider (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     enable,
   input  logic                                     in_valid,
   input  logic [qg_pkg::LANES-1:0][qg_pkg::NUM_W-1:0] in_num,
   input  logic [qg_pkg::DEN_W-1:0]                 in_den,
   input  logic [qg_pkg::LANES-1:0]                 in_neg,
   input  qg_pkg::side_type                         in_side,
   output logic                                     out_valid,
   output logic [qg_pkg::LANES-1:0][qg_pkg::Q_W-1:0] out_quo,
   output logic [qg_pkg::LANES-1:0]                 out_ovf,
   output logic [qg_pkg::LANES-1:0]                 out_neg,
   output qg_pkg::side_type                         out_side
);

   localparam int LANES = qg_pkg::LANES;
   localparam int NUM_W = qg_pkg::NUM_W;
   localparam int DEN_W = qg_pkg::DEN_W;
   localparam int Q_W   = qg_pkg::Q_W;

   logic                   valid_ff [Q_W+1];
   logic [DEN_W-1:0]       den_ff   [Q_W];
   logic [LANES-1:0]       ovf_ff   [Q_W+1];
   logic [LANES-1:0]       neg_ff   [Q_W+1];
   qg_pkg::side_type       side_ff  [Q_W+1];
   logic [DEN_W-1:0]       rem_ff   [Q_W][LANES];
   logic [DEN_W-1:0]       rem_in   [Q_W][LANES];
   logic [Q_W-1:0]         quo_ff   [Q_W+1][LANES];
   logic [Q_W-1:0]         quo_in   [Q_W+1][LANES];
   logic [LANES-1:0]       ovf_in;

   always_comb begin
      logic [DEN_W:0] t;
      logic           ge;
      for (int l = 0; l < LANES; l++) begin
         rem_in[0][l] = DEN_W'(in_num[l][NUM_W-1:Q_W]);
         quo_in[0][l] = in_num[l][Q_W-1:0];
         ovf_in[l]    = DEN_W'(in_num[l][NUM_W-1:Q_W]) >= in_den;
      end
      for (int k = 1; k <= Q_W; k++) begin
         for (int l = 0; l < LANES; l++) begin
            t  = {rem_ff[k-1][l], quo_ff[k-1][l][Q_W-1]};
            ge = t >= {1'b0, den_ff[k-1]};
            if (k < Q_W) begin
               rem_in[k][l] = ge ? DEN_W'(t - {1'b0, den_ff[k-1]}) : DEN_W'(t);
            end
            quo_in[k][l] = {quo_ff[k-1][l][Q_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= Q_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k <= Q_W; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff[0]  <= in_den;
         ovf_ff[0]  <= ovf_in;
         neg_ff[0]  <= in_neg;
         side_ff[0] <= in_side;
         for (int k = 1; k <= Q_W; k++) begin
            ovf_ff[k]  <= ovf_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
         for (int k = 1; k < Q_W; k++) begin
            den_ff[k] <= den_ff[k-1];
         end
         for (int k = 0; k < Q_W; k++) begin
            rem_ff[k] <= rem_in[k];
         end
         for (int k = 0; k <= Q_W; k++) begin
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = quo_ff[Q_W][l];
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_ovf   = ovf_ff[Q_W];
   assign out_neg   = neg_ff[Q_W];
   assign out_side  = side_ff[Q_W];

endmodule

// ----- rtl/qg_back.sv -----
// back end: derivative division, saturation, degenerate masking and result register
// depends on qg_pkg and qg_divider
module qg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  qg_pkg::work_type  in_item,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_stall,
   output qg_pkg::rsp_type   out_item
);

   localparam int LANES = qg_pkg::LANES;
   localparam int Q_W   = qg_pkg::Q_W;
   localparam int CRD_W = qg_pkg::CRD_W;

   logic                            adv;
   logic                            d_valid;
   logic [LANES-1:0][Q_W-1:0]       d_quo;
   logic [LANES-1:0]                d_ovf;
   logic [LANES-1:0]                d_neg;
   qg_pkg::side_type                d_side;
   logic [LANES-1:0][CRD_W-1:0]     res;
   qg_pkg::rsp_type                 rsp_in;
   qg_pkg::rsp_type                 rsp_ff;
   logic                            valid_ff;

   assign adv = !valid_ff || !out_stall;
   assign pop = in_valid && adv;

   qg_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (pop),
      .in_num    (in_item.num),
      .in_den    (in_item.den),
      .in_neg    (in_item.neg),
      .in_side   (in_item.side),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_ovf   (d_ovf),
      .out_neg   (d_neg),
      .out_side  (d_side)
   );

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (d_side.degenerate) begin
            res[l] = '0;
         end else if (!d_neg[l]) begin
            res[l] = (d_ovf[l] || d_quo[l][Q_W-1]) ? {1'b0, {(CRD_W-1){1'b1}}}
                                                   : CRD_W'(d_quo[l]);
         end else begin
            res[l] = (d_ovf[l] || (d_quo[l][Q_W-1] && d_quo[l][Q_W-2:0] != '0))
                   ? {1'b1, {(CRD_W-1){1'b0}}} : CRD_W'(-d_quo[l]);
         end
      end
      rsp_in.point_x      = d_side.point_x;
      rsp_in.point_y      = d_side.point_y;
      rsp_in.point_volume = d_side.volume;
      rsp_in.degenerate   = d_side.degenerate;
      for (int i = 0; i < 4; i++) begin
         rsp_in.dx[i] = res[i];
         rsp_in.dy[i] = res[i+4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = rsp_ff;

endmodule

// ----- rtl/quad4_gauss_point_geometry_core.sv -----
// top level of the quad4 gauss point geometry core: weight register, front, queue, back
// depends on qg_pkg, qg_front, qg_queue, qg_back and assert_macros.svh
//
//   port group  direction  handshake            carries
//   req_        in         req_valid/req_stall  four corner coordinates, gauss index
//   rsp_        out        rsp_valid/rsp_stall  position, volume, derivatives, flag
//   csr_        in         csr_wr_en            gauss weight, unsigned q3.16
//
// one item per cycle sustained while rsp_stall is low; the path holds 7 front stages, one queue
// slot, 33 divider stages (input register and one per quotient bit) and the result register
// the four-entry queue lets the front keep accepting items while the back is stalled, until the queue is full
// reset clears valid state and sets the weight to 1.0; no clearing pass
`include "assert_macros.svh"

module quad4_gauss_point_geometry_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [qg_pkg::W_W-1:0]             csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [qg_pkg::CRD_W-1:0]    req_node0_x,
   input  logic signed [qg_pkg::CRD_W-1:0]    req_node0_y,
   input  logic signed [qg_pkg::CRD_W-1:0]    req_node1_x,
   input  logic signed [qg_pkg::CRD_W-1:0]    req_node1_y,
   input  logic signed [qg_pkg::CRD_W-1:0]    req_node2_x,
   input  logic signed [qg_pkg::CRD_W-1:0]    req_node2_y,
   input  logic signed [qg_pkg::CRD_W-1:0]    req_node3_x,
   input  logic signed [qg_pkg::CRD_W-1:0]    req_node3_y,
   input  logic [1:0]                         req_gauss_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [qg_pkg::CRD_W-1:0]    rsp_point_x,
   output logic signed [qg_pkg::CRD_W-1:0]    rsp_point_y,
   output logic signed [qg_pkg::VOL_W-1:0]    rsp_point_volume,
   output logic signed [qg_pkg::CRD_W-1:0]    rsp_dx_node0,
   output logic signed [qg_pkg::CRD_W-1:0]    rsp_dx_node1,
   output logic signed [qg_pkg::CRD_W-1:0]    rsp_dx_node2,
   output logic signed [qg_pkg::CRD_W-1:0]    rsp_dx_node3,
   output logic signed [qg_pkg::CRD_W-1:0]    rsp_dy_node0,
   output logic signed [qg_pkg::CRD_W-1:0]    rsp_dy_node1,
   output logic signed [qg_pkg::CRD_W-1:0]    rsp_dy_node2,
   output logic signed [qg_pkg::CRD_W-1:0]    rsp_dy_node3,
   output logic                               rsp_degenerate
);

   logic [qg_pkg::W_W-1:0]          weight_ff;
   logic signed [qg_pkg::CRD_W-1:0] node_x [4];
   logic signed [qg_pkg::CRD_W-1:0] node_y [4];
   logic                            f_valid;
   qg_pkg::work_type                f_item;
   logic                            q_full;
   logic                            q_nonempty;
   logic                            q_push;
   logic                            q_pop;
   qg_pkg::work_type                q_head;
   qg_pkg::rsp_type                 rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= qg_pkg::WEIGHT_RESET;
      end else if (csr_wr_en) begin
         weight_ff <= csr_wr_data;
      end
   end

   assign node_x[0] = req_node0_x;
   assign node_x[1] = req_node1_x;
   assign node_x[2] = req_node2_x;
   assign node_x[3] = req_node3_x;
   assign node_y[0] = req_node0_y;
   assign node_y[1] = req_node1_y;
   assign node_y[2] = req_node2_y;
   assign node_y[3] = req_node3_y;

   qg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .weight    (weight_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_x      (node_x),
      .in_y      (node_y),
      .in_idx    (req_gauss_index),
      .out_full  (q_full),
      .out_valid (f_valid),
      .out_item  (f_item)
   );

   assign q_push = f_valid && !q_full;

   qg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (f_item),
      .pop       (q_pop),
      .full      (q_full),
      .nonempty  (q_nonempty),
      .head      (q_head)
   );

   qg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_nonempty),
      .in_item   (q_head),
      .pop       (q_pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (rsp)
   );

   assign rsp_point_x      = rsp.point_x;
   assign rsp_point_y      = rsp.point_y;
   assign rsp_point_volume = rsp.point_volume;
   assign rsp_dx_node0     = $signed(rsp.dx[0]);
   assign rsp_dx_node1     = $signed(rsp.dx[1]);
   assign rsp_dx_node2     = $signed(rsp.dx[2]);
   assign rsp_dx_node3     = $signed(rsp.dx[3]);
   assign rsp_dy_node0     = $signed(rsp.dy[0]);
   assign rsp_dy_node1     = $signed(rsp.dy[1]);
   assign rsp_dy_node2     = $signed(rsp.dy[2]);
   assign rsp_dy_node3     = $signed(rsp.dy[3]);
   assign rsp_degenerate   = rsp.degenerate;

   `QG_ASSERT(a_degen_zero, clock, reset, (rsp_valid && rsp_degenerate) |-> (rsp.dx == '0 && rsp.dy == '0), "degenerate item with nonzero derivatives")
   `QG_ASSERT(a_degen_volume, clock, reset, (rsp_valid && rsp_degenerate) |-> (rsp_point_volume <= 0), "degenerate item with positive volume")

endmodule
